@@ rtl/core/frame_cache_farthest_replace_defines.svh @@
// assertion macros for the frame cache directory checker
`ifndef FRAME_CACHE_FARTHEST_REPLACE_DEFINES_SVH
`define FRAME_CACHE_FARTHEST_REPLACE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FCFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FCFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/fcfr_pkg.sv @@
// types and constants of the frame cache directory
package fcfr_pkg;

  localparam int FRAME_W   = 20;
  localparam int TIME_W    = 28;
  localparam int FRAC_BITS = 8;
  localparam int CFG_W     = 5;
  localparam int SLOT_W    = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_FLUSH   = 1'b1;

  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic [FRAME_W-1:0] frame;
    logic [TIME_W-1:0]  current_time;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
  } rsp_t;

  // search packet walking down the cell row
  typedef struct packed {
    logic               vld;
    logic [FRAME_W-1:0] frame;
    logic [TIME_W-1:0]  now;
    logic               hit;
    logic               empty_found;
    logic               best_found;
    logic [TIME_W-1:0]  best_dist;
  } scan_t;

  // tag write and flush broadcast to every cell
  typedef struct packed {
    logic               flush;
    logic               we;
    logic [FRAME_W-1:0] frame;
  } wr_t;

endpackage

@@ rtl/core/fcfr_cell.sv @@
// one directory slot: tag, valid bit and one stage of the search row
module fcfr_cell #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  fcfr_pkg::scan_t      scan_in,
  input  logic [IDX_W-1:0]     hit_idx_in,
  input  logic [IDX_W-1:0]     empty_idx_in,
  input  logic [IDX_W-1:0]     best_idx_in,
  output fcfr_pkg::scan_t      scan_out,
  output logic [IDX_W-1:0]     hit_idx_out,
  output logic [IDX_W-1:0]     empty_idx_out,
  output logic [IDX_W-1:0]     best_idx_out,
  input  fcfr_pkg::wr_t        wr,
  input  logic [IDX_W-1:0]     wr_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [fcfr_pkg::FRAME_W-1:0] tag;
  logic                         valid;
  logic [fcfr_pkg::TIME_W-1:0]  tag_fix;
  logic [fcfr_pkg::TIME_W-1:0]  gap;
  fcfr_pkg::scan_t              scan_next;
  logic [IDX_W-1:0]             hit_idx_next;
  logic [IDX_W-1:0]             empty_idx_next;
  logic [IDX_W-1:0]             best_idx_next;

  assign tag_fix = {tag, {fcfr_pkg::FRAC_BITS{1'b0}}};
  assign gap     = (scan_in.now >= tag_fix) ? (scan_in.now - tag_fix)
                                            : (tag_fix - scan_in.now);

  always_comb begin
    scan_next      = scan_in;
    hit_idx_next   = hit_idx_in;
    empty_idx_next = empty_idx_in;
    best_idx_next  = best_idx_in;
    if (scan_in.vld && en) begin
      if (valid && tag == scan_in.frame && !scan_in.hit) begin
        scan_next.hit = 1'b1;
        hit_idx_next  = MY_IDX;
      end
      if (!valid && !scan_in.empty_found) begin
        scan_next.empty_found = 1'b1;
        empty_idx_next        = MY_IDX;
      end
      if (valid && gap > scan_in.best_dist) begin
        scan_next.best_found = 1'b1;
        scan_next.best_dist  = gap;
        best_idx_next        = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= 1'b0;
      scan_out.vld <= 1'b0;
    end else begin
      scan_out.vld <= scan_next.vld;
      if (wr.flush) begin
        valid <= 1'b0;
      end else if (wr.we && wr_idx == MY_IDX) begin
        valid <= 1'b1;
      end
    end
    if (wr.we && wr_idx == MY_IDX) begin
      tag <= wr.frame;
    end
    scan_out.frame       <= scan_next.frame;
    scan_out.now         <= scan_next.now;
    scan_out.hit         <= scan_next.hit;
    scan_out.empty_found <= scan_next.empty_found;
    scan_out.best_found  <= scan_next.best_found;
    scan_out.best_dist   <= scan_next.best_dist;
    hit_idx_out          <= hit_idx_next;
    empty_idx_out        <= empty_idx_next;
    best_idx_out         <= best_idx_next;
  end

endmodule

@@ rtl/core/frame_cache_farthest_replace.sv @@
// frame cache slot directory with farthest-frame replacement, top level
//
// req channel: opcode, frame, current_time; taken when req_valid is high and
// req_stall is low. rsp channel: status and slot; taken when rsp_valid is
// high and rsp_stall is low. cfg channel: slots_in_use, always ready.
// a request walks a row of MAX_SLOTS cells, one cell per cycle; each cell
// checks its tag for a hit, notes the first empty slot and keeps the farthest
// tag. the response is registered in the cycle after the last cell, and a
// flush is answered in the cycle after it is taken. the chosen slot gets
// its new tag in the same cycle the response is loaded.
// one item is in flight at a time: req_stall stays high from acceptance until
// the response is taken. a stalled response holds its value and keeps the
// block from taking items. reset empties every slot, sets slots_in_use to 4
// and clears both channels.
module frame_cache_farthest_replace #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  fcfr_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output fcfr_pkg::rsp_t             rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fcfr_pkg::CFG_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [fcfr_pkg::CFG_W-1:0] slots_in_use;
  logic                       busy;
  logic                       accept;
  logic                       flush_acc;
  fcfr_pkg::wr_t              wr;
  logic [IDX_W-1:0]           wr_idx;
  logic [MAX_SLOTS-1:0]       en;

  fcfr_pkg::scan_t  scan      [MAX_SLOTS+1];
  logic [IDX_W-1:0] hit_idx   [MAX_SLOTS+1];
  logic [IDX_W-1:0] empty_idx [MAX_SLOTS+1];
  logic [IDX_W-1:0] best_idx  [MAX_SLOTS+1];

  fcfr_pkg::scan_t fin;
  fcfr_pkg::rsp_t  rsp_next;

  assign cfg_ready = 1'b1;
  assign req_stall = busy;
  assign accept    = req_valid && !req_stall;
  assign flush_acc = accept && req.opcode == fcfr_pkg::OP_FLUSH;

  always_comb begin
    scan[0].vld         = accept && req.opcode == fcfr_pkg::OP_REQUEST;
    scan[0].frame       = req.frame;
    scan[0].now         = req.current_time;
    scan[0].hit         = 1'b0;
    scan[0].empty_found = 1'b0;
    scan[0].best_found  = 1'b0;
    scan[0].best_dist   = '0;
    hit_idx[0]          = '0;
    empty_idx[0]        = '0;
    best_idx[0]         = '0;
  end

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    assign en[i] = 32'(slots_in_use) > 32'(i);
    fcfr_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .en            (en[i]),
      .scan_in       (scan[i]),
      .hit_idx_in    (hit_idx[i]),
      .empty_idx_in  (empty_idx[i]),
      .best_idx_in   (best_idx[i]),
      .scan_out      (scan[i+1]),
      .hit_idx_out   (hit_idx[i+1]),
      .empty_idx_out (empty_idx[i+1]),
      .best_idx_out  (best_idx[i+1]),
      .wr            (wr),
      .wr_idx        (wr_idx)
    );
  end

  assign fin = scan[MAX_SLOTS];

  always_comb begin
    wr.flush = flush_acc;
    wr.we    = fin.vld && !fin.hit && (fin.empty_found || fin.best_found);
    wr.frame = fin.frame;
    wr_idx   = fin.empty_found ? empty_idx[MAX_SLOTS] : best_idx[MAX_SLOTS];
    if (fin.hit) begin
      rsp_next.status = fcfr_pkg::ST_HIT;
      rsp_next.slot   = fcfr_pkg::SLOT_W'(hit_idx[MAX_SLOTS]);
    end else if (fin.empty_found || fin.best_found) begin
      rsp_next.status = fcfr_pkg::ST_MISS;
      rsp_next.slot   = fcfr_pkg::SLOT_W'(wr_idx);
    end else begin
      rsp_next.status = fcfr_pkg::ST_NONE;
      rsp_next.slot   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= fcfr_pkg::CFG_RESET;
      busy         <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slots_in_use <= cfg_data;
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
        busy      <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
      end
      if (flush_acc || fin.vld) begin
        rsp_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flush_acc) begin
      rsp.status <= fcfr_pkg::ST_FLUSH;
      rsp.slot   <= '0;
    end else if (fin.vld) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ rtl/core/fcfr_checker.sv @@
// port-level checker for the frame cache directory, bound to the top level
`include "frame_cache_farthest_replace_defines.svh"

module fcfr_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input fcfr_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input fcfr_pkg::rsp_t rsp
);

  `FCFR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp dropped or changed while stalled")
  `FCFR_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall, "item taken while another is in flight")
  `FCFR_ASSERT_NEXT(a_flush_done, req_valid && !req_stall && req.opcode == fcfr_pkg::OP_FLUSH, rsp_valid && rsp.status == fcfr_pkg::ST_FLUSH, "flush not answered next cycle")
  `FCFR_ASSERT_NOW(a_slot_zero, rsp_valid && (rsp.status == fcfr_pkg::ST_NONE || rsp.status == fcfr_pkg::ST_FLUSH), rsp.slot == '0, "slot nonzero without an assigned slot")

endmodule

bind frame_cache_farthest_replace fcfr_checker u_fcfr_checker (.*);
